FILE: src/assert_macros.svh
// Shared assertion macros for the bit packer checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define PCBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define PCBP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/pcbp_pkg.sv
package pcbp_pkg;

    localparam int SYM_W        = 8;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int KIND_W       = 2;
    localparam int BYTE_W       = 8;
    localparam int PEND_W       = 7;
    localparam int CNT_W        = 3;
    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;
    localparam int ACC_W        = PEND_W + CODE_W;
    localparam int IN_DATA_W    = 48;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

    // Complete bytes of one item, right-aligned, first byte highest
    typedef struct packed {
        logic [CODE_W-1:0] word;
        logic [CNT_W-1:0]  count;
        logic              eos;
    } burst_t;

endpackage

FILE: src/pcbp_table.sv
module pcbp_table
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic                         rd_en,
    input  logic [pcbp_pkg::SYM_W-1:0]   addr,
    input  pcbp_pkg::entry_t             wr_data,
    output pcbp_pkg::entry_t             rd_data
);
    import pcbp_pkg::*;

    entry_t mem [SYMBOL_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

FILE: src/pcbp_packer.sv
module pcbp_packer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_accept,
    input  logic [pcbp_pkg::KIND_W-1:0]   in_kind,
    output logic                          in_ready,
    input  pcbp_pkg::entry_t              entry,
    output logic                          burst_valid,
    input  logic                          burst_ready,
    output pcbp_pkg::burst_t              burst
);
    import pcbp_pkg::*;

    logic              valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [PEND_W-1:0] pend_bits_reg, pend_bits_next;
    logic [CNT_W-1:0]  pend_cnt_reg, pend_cnt_next;

    logic              is_sym;
    logic              is_flush;
    logic [LEN_W-1:0]  len_eff;
    logic [CODE_W-1:0] masked;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  shifted;
    logic [LEN_W-1:0]  total;
    logic [CNT_W-1:0]  nbytes;
    logic [BYTE_W-1:0] flush_byte;
    logic              gen;
    logic              advance;

    assign is_sym   = (kind_reg == KIND_SYMBOL);
    assign is_flush = (kind_reg == KIND_FLUSH);

    always_comb
    begin
        len_eff = (entry.len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : entry.len;
        masked  = entry.code & ~({CODE_W{1'b1}} << len_eff);
        acc     = ({{CODE_W{1'b0}}, pend_bits_reg} << len_eff) | {{PEND_W{1'b0}}, masked};
        total   = {{(LEN_W-CNT_W){1'b0}}, pend_cnt_reg} + len_eff;
        nbytes  = total[LEN_W-1:3];
        shifted = acc >> total[2:0];
        // Left-align the leftover bits and pad with zeros
        flush_byte = {1'b0, pend_bits_reg} << (4'd8 - {1'b0, pend_cnt_reg});
    end

    assign gen = (is_sym && (nbytes != '0)) || (is_flush && (pend_cnt_reg != '0));
    assign advance     = valid_reg && (!gen || burst_ready);
    assign in_ready    = !valid_reg || advance;
    assign burst_valid = valid_reg && gen;

    always_comb
    begin
        burst.eos = is_flush;
        if (is_flush)
        begin
            burst.word  = {{(CODE_W-BYTE_W){1'b0}}, flush_byte};
            burst.count = CNT_W'(1);
        end
        else
        begin
            burst.word  = shifted[CODE_W-1:0];
            burst.count = nbytes;
        end
    end

    always_comb
    begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (advance && is_sym)
        begin
            pend_bits_next = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[2:0]);
            pend_cnt_next  = total[CNT_W-1:0];
        end
        else if (advance && is_flush)
        begin
            pend_bits_next = '0;
            pend_cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            if (in_accept)
            begin
                valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg <= in_kind;
        end
    end

endmodule

FILE: src/pcbp_emitter.sv
module pcbp_emitter
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           burst_valid,
    output logic                           burst_ready,
    input  pcbp_pkg::burst_t               burst,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pcbp_pkg::BYTE_W-1:0]    out_byte,
    output logic                           out_last,
    output logic                           out_eos
);
    import pcbp_pkg::*;

    logic [CODE_W-1:0] word_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              eos_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              out_eos_reg;

    logic              out_load;
    logic              take;
    logic [1:0]        idx;

    assign out_load    = (cnt_reg != '0) && (!out_valid_reg || out_ready);
    assign burst_ready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_load);
    assign take        = burst_valid && burst_ready;
    // Highest remaining byte goes out first
    assign idx         = cnt_reg[1:0] - 2'd1;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (take)
        begin
            cnt_next = burst.count;
        end
        else if (out_load)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= burst.word;
            eos_reg  <= burst.eos;
        end
        if (out_load)
        begin
            out_byte_reg <= word_reg[idx*BYTE_W +: BYTE_W];
            out_last_reg <= (cnt_reg == CNT_W'(1));
            out_eos_reg  <= eos_reg && (cnt_reg == CNT_W'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_eos   = out_eos_reg;

endmodule

FILE: src/prefix_code_bit_packer_unit.sv
// Prefix-code bit packer: a load transfer (tuser 0) writes one code table entry, a symbol
// transfer (tuser 1) appends that symbol's code MSB-first and sends every complete byte,
// and a flush transfer (tuser 2) sends the leftover bits left-aligned and zero-padded with
// tuser set on the output. tlast marks the last byte caused by one input transfer. The table
// is a 256 x 38 memory with a registered read and no clearing pass; encode only loaded
// symbols. The bytes of a symbol leave one at a time through the one-byte output register,
// and the next item can be taken as the last byte of the one before goes out. The first
// byte of an item passes the table read register, the emitter's word register and the
// output register, and the output can stall it.
module prefix_code_bit_packer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // symbol[7:0], code_word[39:8], code_length[45:40], 0
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // packed_byte[7:0]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser   // end_of_stream[0]
);
    import pcbp_pkg::*;

    logic              in_accept;
    logic [SYM_W-1:0]  symbol;
    entry_t            wr_entry;
    entry_t            rd_entry;
    logic              burst_valid;
    logic              burst_ready;
    burst_t            burst;

    assign in_accept      = s_axis_tvalid && s_axis_tready;
    assign symbol         = s_axis_tdata[SYM_W-1:0];
    assign wr_entry.code  = s_axis_tdata[SYM_W +: CODE_W];
    assign wr_entry.len   = s_axis_tdata[SYM_W+CODE_W +: LEN_W];

    pcbp_table u_table
    (
        .clk     (clk),
        .wr_en   (in_accept && (s_axis_tuser == KIND_LOAD)),
        .rd_en   (in_accept),
        .addr    (symbol),
        .wr_data (wr_entry),
        .rd_data (rd_entry)
    );

    pcbp_packer u_packer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .in_kind     (s_axis_tuser),
        .in_ready    (s_axis_tready),
        .entry       (rd_entry),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst)
    );

    pcbp_emitter u_emitter
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata),
        .out_last    (m_axis_tlast),
        .out_eos     (m_axis_tuser)
    );

endmodule

FILE: src/pcbp_checker.sv
`include "assert_macros.svh"

module pcbp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [47:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // Hold a stalled output transfer unchanged
    `PCBP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled output transfer changed")

    // A flush yields exactly one byte, so it closes its run
    `PCBP_ASSERT(a_eos_last, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "end_of_stream byte without tlast")

    // Nothing leaves the block right after reset
    `PCBP_ASSERT_ALWAYS(a_rst_quiet, !$past(rst_n) |-> !m_axis_tvalid, "output valid right after reset")

endmodule

bind prefix_code_bit_packer_unit pcbp_checker u_pcbp_checker (.*);

FILE: bench/tb_top.sv
module tb_top;
    import pcbp_pkg::*;

    // kind value that the block ignores
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 1000;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              eos;
    } packed_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // symbol[7:0], code_word[39:8], code_length[45:40], 0
    logic [1:0]  s_axis_tuser = '0;   // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [7:0]  m_axis_tdata;        // packed_byte[7:0]
    logic        m_axis_tlast;
    logic        m_axis_tuser;        // end_of_stream[0]

    // own copy of the code table and the bit accumulator
    logic [CODE_W-1:0] code_tbl [SYMBOL_COUNT];
    logic [LEN_W-1:0]  len_tbl [SYMBOL_COUNT];
    logic [PEND_W-1:0] pend_bits = '0;
    logic [CNT_W-1:0]  pend_cnt = '0;

    bit                sym_loaded [SYMBOL_COUNT];
    logic [SYM_W-1:0]  loaded_syms [$];
    packed_byte_t      expected_bytes [$];

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    prefix_code_bit_packer_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void predict_packed_bytes(input logic [KIND_W-1:0] kind,
                                                 input logic [SYM_W-1:0]  sym,
                                                 input logic [CODE_W-1:0] word,
                                                 input logic [LEN_W-1:0]  len);
        int           eff;
        int           total;
        logic [63:0]  acc;
        logic [63:0]  shifted;
        logic [15:0]  padded;
        packed_byte_t e;
        case (kind)
            KIND_LOAD:
            begin
                code_tbl[sym] = word;
                len_tbl[sym]  = len;
            end
            KIND_SYMBOL:
            begin
                eff = len_tbl[sym];
                if (eff > MAX_CODE_LEN)
                    eff = MAX_CODE_LEN;
                if (eff > CODE_W)
                    eff = CODE_W;
                if (eff != 0)
                begin
                    acc = ({57'd0, pend_bits} << eff)
                        | ({32'd0, code_tbl[sym]} & ((64'd1 << eff) - 64'd1));
                    total = pend_cnt + eff;
                    while (total >= 8)
                    begin
                        total -= 8;
                        shifted = acc >> total;
                        e.data = shifted[7:0];
                        e.last = (total < 8);
                        e.eos  = 1'b0;
                        expected_bytes.push_back(e);
                    end
                    shifted   = acc & ((64'd1 << total) - 64'd1);
                    pend_bits = shifted[PEND_W-1:0];
                    pend_cnt  = total[CNT_W-1:0];
                end
            end
            KIND_FLUSH:
            begin
                if (pend_cnt != 0)
                begin
                    padded = {9'd0, pend_bits} << (8 - pend_cnt);
                    e.data = padded[7:0];
                    e.last = 1'b1;
                    e.eos  = 1'b1;
                    expected_bytes.push_back(e);
                    pend_bits = '0;
                    pend_cnt  = '0;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Compare each output transfer with the oldest expected byte
    always @(posedge clk)
    begin
        packed_byte_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
            else
            begin
                e = expected_bytes.pop_front();
                if (m_axis_tdata !== e.data)
                    report_mismatch($sformatf("packed_byte %02h, want %02h",
                                              m_axis_tdata, e.data));
                if (m_axis_tlast !== e.last)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              m_axis_tlast, e.last));
                if (m_axis_tuser !== e.eos)
                    report_mismatch($sformatf("end_of_stream %b, want %b",
                                              m_axis_tuser, e.eos));
            end
        end
    end

    // End the run when nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Receiver: stall in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else if (sink_idle_en && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
        if (src_idle_en && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {2'b00, len, word, sym};
        do @(posedge clk); while (!s_axis_tready);
        predict_packed_bytes(kind, sym, word, len);
        if (kind == KIND_LOAD && !sym_loaded[sym])
        begin
            sym_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
        @(negedge clk);
    endtask

    task automatic wait_for_drain;
        s_axis_tvalid = 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_code_length;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 12)
            return LEN_W'($urandom_range(33, 63));
        else if (r < 30)
            return LEN_W'($urandom_range(17, 32));
        return LEN_W'($urandom_range(1, 16));
    endfunction

    task automatic send_random_item;
        int r;
        r = $urandom_range(0, 99);
        if (r < 10 || loaded_syms.size() == 0)
            send_item(KIND_LOAD, SYM_W'($urandom_range(0, 255)), $urandom, pick_code_length());
        else if (r < 82)
            // code fields ride along as noise; the block ignores them here
            send_item(KIND_SYMBOL, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                      $urandom, LEN_W'($urandom_range(0, 63)));
        else if (r < 94)
            send_item(KIND_FLUSH, SYM_W'($urandom_range(0, 255)), $urandom,
                      LEN_W'($urandom_range(0, 63)));
        else
            send_item(KIND_UNUSED, SYM_W'($urandom_range(0, 255)), $urandom,
                      LEN_W'($urandom_range(0, 63)));
    endtask

    task automatic test_directed_edges;
        send_item(KIND_FLUSH, 8'd0, 32'd0, 6'd0);
        send_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send_item(KIND_LOAD, 8'd0, 32'd0, 6'd1);
        send_item(KIND_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
        send_item(KIND_LOAD, 8'd1, 32'h0000_1234, 6'd0);
        send_item(KIND_LOAD, 8'd2, 32'hA5A5_5A5A, 6'h3F);
        send_item(KIND_LOAD, 8'd3, 32'h0F0F_0F0F, 6'd33);
        send_item(KIND_LOAD, 8'd4, 32'h0000_00C3, 6'd8);
        send_item(KIND_LOAD, 8'd5, 32'hFFFF_FF55, 6'd7);
        send_item(KIND_SYMBOL, 8'd0, 32'd0, 6'd0);
        send_item(KIND_SYMBOL, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        // zero length appends nothing
        send_item(KIND_SYMBOL, 8'd1, 32'd0, 6'd0);
        // oversize lengths act as 32 bits
        send_item(KIND_SYMBOL, 8'd2, 32'd0, 6'd0);
        send_item(KIND_SYMBOL, 8'd3, 32'd0, 6'd0);
        send_item(KIND_SYMBOL, 8'd4, 32'd0, 6'd0);
        send_item(KIND_SYMBOL, 8'd5, 32'd0, 6'd0);
        send_item(KIND_SYMBOL, 8'd0, 32'd0, 6'd0);
        send_item(KIND_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send_item(KIND_FLUSH, 8'd0, 32'd0, 6'd0);
        send_item(KIND_SYMBOL, 8'd4, 32'd0, 6'd0);
        send_item(KIND_FLUSH, 8'd0, 32'd0, 6'd0);
    endtask

    task automatic test_table_fill;
        repeat (40)
            send_item(KIND_LOAD, SYM_W'($urandom_range(0, 255)), $urandom, pick_code_length());
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count)
            send_random_item();
    endtask

    task automatic test_drain_pause;
        repeat (3)
        begin
            repeat (15)
                send_random_item();
            wait_for_drain();
        end
    endtask

    // long codes give the most bytes per symbol
    task automatic test_long_codes;
        logic [SYM_W-1:0] long_syms [$];
        logic [SYM_W-1:0] s;
        repeat (16)
        begin
            s = SYM_W'($urandom_range(0, 255));
            send_item(KIND_LOAD, s, $urandom, LEN_W'($urandom_range(25, 32)));
            long_syms.push_back(s);
        end
        repeat (30)
            send_item(KIND_SYMBOL, long_syms[$urandom_range(0, long_syms.size() - 1)],
                      $urandom, LEN_W'($urandom_range(0, 63)));
    endtask

    task automatic test_full_rate;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (80)
            send_random_item();
        send_item(KIND_FLUSH, 8'd0, 32'd0, 6'd0);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_edges();
        test_table_fill();
        test_random_traffic(110);
        test_drain_pause();
        test_long_codes();
        test_full_rate();
        wait_for_drain();
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
